// ===== hdl/key_debounce_autorepeat_top_defines.svh =====
// Assertion macros for the key debounce block.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kda assertion failed");
`define KDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kda assertion failed");
`else
`define KDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/kda_pkg.sv =====
package kda_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] key;
    logic       level;
  } kda_in_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_kind;
    logic [2:0] event_key;
    logic [7:0] double_count;
  } kda_out_t;

  typedef struct packed {
    logic [7:0] history;
    logic [7:0] tick;
    logic [3:0] phase;
    logic [7:0] press;
  } kda_entry_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } kda_event_t;

  localparam int ENTRY_W = $bits(kda_entry_t);

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_PAUSE  = 2'd1;
  localparam logic [1:0] MODE_KILL   = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] EV_FIRST = 2'd0;
  localparam logic [1:0] EV_REPT  = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;
  localparam logic [1:0] EV_BREAK = 2'd3;

  localparam logic [3:0] PH_OFF    = 4'd0;
  localparam logic [3:0] PH_R1     = 4'd1;
  localparam logic [3:0] PH_R2     = 4'd2;
  localparam logic [3:0] PH_R4     = 4'd3;
  localparam logic [3:0] PH_R8     = 4'd4;
  localparam logic [3:0] PH_R16    = 4'd5;
  localparam logic [3:0] PH_START  = 4'd6;
  localparam logic [3:0] PH_DELAY  = 4'd7;
  localparam logic [3:0] PH_PAUSE  = 4'd8;
  localparam logic [3:0] PH_KILLED = 4'd9;

  localparam logic [7:0] EARLY_DELAY_TICKS = 8'd20;
  localparam logic [7:0] EARLY_R16_TICKS   = 8'd16;
  localparam logic [7:0] IDLE_PRESS_TICKS  = 8'd20;
  localparam logic [7:0] IDLE_ZERO_TICKS   = 8'd30;
  localparam logic [7:0] LONG_TICK         = 8'd38;
  localparam logic [7:0] DELAY_TICKS       = 8'd40;
  localparam logic [7:0] SPEEDUP_TICKS     = 8'd48;
  localparam logic [7:0] PAUSE_TICKS       = 8'd64;

endpackage

// ===== hdl/key_debounce_autorepeat_top.sv =====
// Data path: an input transfer loads the stage-1 register, and its result is held in the
// output register; an output stall (out_ready low) can hold either stage.
// Throughput: one item per cycle while out_ready does not stall the output, set by the single
// read-modify-write pass over the per-key state memory, with forwarding of the last write.
// Reset: synchronous active-low; all keys read as zero state, repeat delay on.
`include "key_debounce_autorepeat_top_defines.svh"

module key_debounce_autorepeat_top
  import kda_pkg::*;
  #(
    parameter int NUM_KEYS   = 8,
    parameter int PRESS_BITS = 4
  )
  (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  kda_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output kda_out_t out_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
  );

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [5:0] KEY_LIMIT = 6'(NUM_KEYS);

  logic              delay_mode_r;
  logic              s1_valid_r;
  kda_in_t           s1_item_r;
  logic              s1_inrange_r;
  logic [AW-1:0]     s1_addr_r;
  logic [NUM_KEYS-1:0] init_r;
  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  kda_entry_t        fwd_entry_r;
  logic              out_valid_r;
  kda_out_t          out_data_r;
  kda_out_t          out_data_nxt;

  logic              in_xfer;
  logic              advance;
  logic              commit;
  logic              wr_en;
  logic [AW-1:0]     in_addr;
  logic              in_inrange;
  logic [ENTRY_W-1:0] ram_rdata;
  kda_entry_t        cur_entry;
  kda_entry_t        nxt_entry;
  kda_event_t        evt;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_ready;
  assign in_ready   = !s1_valid_r || advance;
  assign in_xfer    = in_valid && in_ready;
  assign commit     = s1_valid_r && advance;
  assign wr_en      = commit && s1_inrange_r;
  assign in_addr    = AW'(in_data.key);
  assign in_inrange = {3'b000, in_data.key} < KEY_LIMIT;

  kda_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (nxt_entry),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      cur_entry = fwd_entry_r;
    end else if (init_r[s1_addr_r]) begin
      cur_entry = kda_entry_t'(ram_rdata);
    end else begin
      cur_entry = '0;
    end
  end

  kda_update #(
    .PRESS_BITS (PRESS_BITS)
  ) u_update (
    .item       (s1_item_r),
    .cur        (cur_entry),
    .delay_mode (delay_mode_r),
    .nxt        (nxt_entry),
    .evt        (evt)
  );

  always_comb begin
    out_data_nxt = '0;
    if (s1_inrange_r) begin
      out_data_nxt.event_valid  = evt.valid;
      out_data_nxt.event_kind   = evt.kind;
      out_data_nxt.event_key    = evt.valid ? s1_item_r.key : 3'd0;
      out_data_nxt.double_count = nxt_entry.press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_mode_r <= 1'b1;
      s1_valid_r   <= 1'b0;
      init_r       <= '0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delay_mode_r <= cfg_data;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        init_r[s1_addr_r] <= 1'b1;
        fwd_valid_r       <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r    <= in_data;
      s1_inrange_r <= in_inrange;
      s1_addr_r    <= in_addr;
    end
    if (wr_en) begin
      fwd_addr_r  <= s1_addr_r;
      fwd_entry_r <= nxt_entry;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KDA_ASSERT_SAME(a_no_event_fields, clk, rst_n, out_valid && !out_data.event_valid, out_data.event_kind == EV_FIRST && out_data.event_key == 3'd0)
  `KDA_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `KDA_ASSERT_NEXT(a_transfer_enters_stage, clk, rst_n, in_valid && in_ready, s1_valid_r)

endmodule

// ===== hdl/kda_ram.sv =====
module kda_ram
  #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/kda_update.sv =====
module kda_update
  import kda_pkg::*;
  #(
    parameter int PRESS_BITS = 4
  )
  (
    input  kda_in_t    item,
    input  kda_entry_t cur,
    input  logic       delay_mode,
    output kda_entry_t nxt,
    output kda_event_t evt
  );

  localparam logic [7:0] ONES = 8'((1 << PRESS_BITS) - 1);

  always_comb begin
    logic [7:0] h;
    logic [7:0] cnt;
    logic [3:0] ph;
    logic [7:0] dbl;
    logic       valid;
    logic [1:0] kind;
    logic       early;
    logic [3:0] mask;
    h     = cur.history;
    cnt   = cur.tick;
    ph    = cur.phase;
    dbl   = cur.press;
    valid = 1'b0;
    kind  = EV_FIRST;
    early = 1'b0;
    mask  = 4'd0;
    unique case (item.mode)
      MODE_PAUSE: begin
        ph  = PH_PAUSE;
        cnt = 8'd0;
      end
      MODE_KILL: begin
        ph  = PH_KILLED;
        dbl = 8'd0;
      end
      MODE_QUERY: begin
      end
      MODE_SAMPLE: begin
        h   = {cur.history[6:0], item.level};
        cnt = cur.tick + 8'd1;
        if (ph != PH_OFF && h == 8'd0) begin
          if (ph != PH_KILLED) begin
            valid = 1'b1;
            kind  = EV_BREAK;
            if (delay_mode) begin
              early = (ph == PH_DELAY) && (cnt < EARLY_DELAY_TICKS);
            end else begin
              early = (ph == PH_R16) && (cnt < EARLY_R16_TICKS);
            end
            if (!early) begin
              dbl = 8'd0;
            end
          end
          cnt = 8'd0;
          ph  = PH_OFF;
        end
        if (ph == PH_OFF) begin
          if (h == ONES) begin
            ph = PH_START;
            if (cnt > IDLE_PRESS_TICKS) begin
              dbl = 8'd0;
            end
            cnt = 8'd0;
          end else if (h == 8'd0 && cnt > IDLE_ZERO_TICKS) begin
            dbl = 8'd0;
          end
        end else if (ph == PH_START) begin
          valid = 1'b1;
          kind  = EV_FIRST;
          dbl   = dbl + 8'd1;
          ph    = delay_mode ? PH_DELAY : PH_R16;
          cnt   = 8'd0;
        end else if (ph == PH_DELAY) begin
          if (cnt == LONG_TICK) begin
            valid = 1'b1;
            kind  = EV_LONG;
          end
          if (cnt == DELAY_TICKS) begin
            ph  = PH_R16;
            cnt = 8'd0;
          end
        end else if (ph >= PH_R1 && ph <= PH_R16) begin
          if (ph == PH_R16 && !delay_mode && cnt == LONG_TICK) begin
            valid = 1'b1;
            kind  = EV_LONG;
          end
          if (ph >= PH_R2 && cnt >= SPEEDUP_TICKS) begin
            ph  = ph - 4'd1;
            cnt = 8'd0;
          end
          case (ph)
            PH_R2:   mask = 4'b0001;
            PH_R4:   mask = 4'b0011;
            PH_R8:   mask = 4'b0111;
            PH_R16:  mask = 4'b1111;
            default: mask = 4'b0000;
          endcase
          if (!valid && (cnt[3:0] & mask) == 4'd0) begin
            valid = 1'b1;
            kind  = EV_REPT;
          end
        end else if (ph == PH_PAUSE) begin
          if (cnt >= PAUSE_TICKS) begin
            ph  = PH_R8;
            cnt = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase
    nxt.history = h;
    nxt.tick    = cnt;
    nxt.phase   = ph;
    nxt.press   = dbl;
    evt.valid   = valid;
    evt.kind    = valid ? kind : EV_FIRST;
  end

endmodule
